### hw/rtl/hcbp_pkg.sv
// Shared types, constants and operation codes for the Huffman code bit packer.
// Used by every module of the block; it depends on nothing else.
package hcbp_pkg;

  localparam int SYMBOL_W            = 7;
  localparam int CODE_W              = 16;
  localparam int LEN_W               = 5;
  localparam int MAX_CODE_BITS       = 16;
  localparam int DEFAULT_NUM_SYMBOLS = 128;

  // Pending bits live below one byte, so a code plus the pending bits fit here.
  localparam int PEND_W  = 7;
  localparam int PCNT_W  = 3;
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int TOTAL_W = 5;

  localparam int OQ_DEPTH  = 4;
  localparam int OQ_PTR_W  = 2;
  localparam int OQ_FILL_W = 3;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic              has_code;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    logic [7:0] data0;
    logic       last0;
    logic [7:0] data1;
    logic       last1;
  } push_t;

endpackage

### hw/rtl/huffman_code_bit_packer_top.sv
// Huffman code bit packer: table lookup, MSB-first packing, output queue.
// A word caused by an item passes the input register stage and the output queue before it can be taken.
// Throughput: one item per cycle while each item yields at most one word and out_ready stays
// high; items that yield two words are held back by the single-word output port.
// Reset (rst, synchronous) clears the table's entry-valid bits, the pending bits and the queue.
// Depends on hcbp_pkg, hcbp_table, hcbp_packer and hcbp_out_fifo.
module huffman_code_bit_packer_top #(
  parameter int NUM_SYMBOLS = hcbp_pkg::DEFAULT_NUM_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    operation,
  input  logic [hcbp_pkg::SYMBOL_W-1:0] symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]   code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          last
);
  import hcbp_pkg::*;

  logic  accept;
  logic  advance;
  logic  s1_valid;
  logic  has_room;
  item_t item;
  push_t push;

  assign advance  = s1_valid && has_room;
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  hcbp_table #(
    .NUM_SYMBOLS(NUM_SYMBOLS)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (operation),
    .symbol     (symbol),
    .code_value (code_value),
    .code_length(code_length),
    .advance    (advance),
    .s1_valid   (s1_valid),
    .item       (item)
  );

  hcbp_packer u_packer (
    .clk (clk),
    .rst (rst),
    .fire(advance),
    .item(item),
    .push(push)
  );

  hcbp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .has_room (has_room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .last     (last)
  );

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> s1_valid && $stable(item))
    else $error("held item changed while the queue was full");

  assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted word did not reach the input stage");

  assert property (@(posedge clk) disable iff (rst)
    !advance |-> (push.count == 2'd0))
    else $error("words pushed without a held item");

endmodule

### hw/rtl/hcbp_table.sv
// Code table (code bits and lengths) with the input register stage.
// Depends on hcbp_pkg.
module hcbp_table #(
  parameter int NUM_SYMBOLS = hcbp_pkg::DEFAULT_NUM_SYMBOLS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [1:0]                    operation,
  input  logic [hcbp_pkg::SYMBOL_W-1:0] symbol,
  input  logic [hcbp_pkg::CODE_W-1:0]   code_value,
  input  logic [hcbp_pkg::LEN_W-1:0]    code_length,
  input  logic                          advance,
  output logic                          s1_valid,
  output hcbp_pkg::item_t               item
);
  import hcbp_pkg::*;

  localparam int SYM_SPAN    = 1 << SYMBOL_W;
  localparam int TABLE_DEPTH = (NUM_SYMBOLS > SYM_SPAN) ? SYM_SPAN : NUM_SYMBOLS;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam logic [SYMBOL_W+1:0] NUM_SYM_L = (SYMBOL_W + 2)'(NUM_SYMBOLS);
  localparam logic [LEN_W-1:0]    MAX_LEN   = LEN_W'(MAX_CODE_BITS);

  logic [CODE_W-1:0]      code_mem [TABLE_DEPTH];
  logic [LEN_W-1:0]       len_mem  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] entry_valid;

  logic [IDX_W-1:0]  idx;
  logic              in_range;
  logic              wr_en;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] code_masked;

  logic [1:0]        s1_op;
  logic              s1_in_range;
  logic              s1_entry_valid;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;

  assign idx         = symbol[IDX_W-1:0];
  assign in_range    = {2'b00, symbol} < NUM_SYM_L;
  assign wr_en       = accept && (operation == OP_LOAD) && in_range;
  assign len_sat     = (code_length > MAX_LEN) ? MAX_LEN : code_length;
  // Shifting the all-ones word by the full width leaves zero, so the mask keeps every bit.
  assign code_masked = code_value & ~({CODE_W{1'b1}} << len_sat);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[idx] <= code_masked;
      len_mem[idx]  <= len_sat;
    end
    if (accept) begin
      rd_code        <= code_mem[idx];
      rd_len         <= len_mem[idx];
      s1_op          <= operation;
      s1_in_range    <= in_range;
      s1_entry_valid <= entry_valid[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_comb begin
    item.op       = s1_op;
    item.has_code = (s1_op == OP_ENCODE) && s1_in_range && s1_entry_valid
                    && (rd_len != '0);
    item.len      = rd_len;
    item.code     = rd_code;
  end

endmodule

### hw/rtl/hcbp_packer.sv
// MSB-first bit packer: holds the pending partial byte and forms up to two
// output words per item. Depends on hcbp_pkg.
module hcbp_packer (
  input  logic            clk,
  input  logic            rst,
  input  logic            fire,
  input  hcbp_pkg::item_t item,
  output hcbp_pkg::push_t push
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0]  pbits;
  logic [PCNT_W-1:0]  pcount;
  logic [PEND_W-1:0]  pbits_next;
  logic [PCNT_W-1:0]  pcount_next;

  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   aligned;
  logic [TOTAL_W-1:0] total;
  logic [PCNT_W-1:0]  rem;
  logic [7:0]         flush_data;

  assign acc   = (ACC_W'(pbits) << item.len) | ACC_W'(item.code);
  assign total = TOTAL_W'(pcount) + TOTAL_W'(item.len);
  assign rem   = total[PCNT_W-1:0];
  // Left-align the accumulated bits so whole bytes come off the top.
  assign aligned    = acc << (TOTAL_W'(ACC_W) - total);
  assign flush_data = 8'({1'b0, pbits} << (4'd8 - {1'b0, pcount}));

  always_comb begin
    push        = '0;
    pbits_next  = pbits;
    pcount_next = pcount;
    if (fire) begin
      if (item.has_code) begin
        push.count  = total[TOTAL_W-1:3];
        push.data0  = aligned[ACC_W-1 -: 8];
        push.data1  = aligned[ACC_W-9 -: 8];
        push.last0  = (total[TOTAL_W-1:3] == 2'd1);
        push.last1  = 1'b1;
        pbits_next  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << rem);
        pcount_next = rem;
      end else if ((item.op == OP_FLUSH) && (pcount != '0)) begin
        push.count  = 2'd1;
        push.data0  = flush_data;
        push.last0  = 1'b1;
        pbits_next  = '0;
        pcount_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbits  <= '0;
      pcount <= '0;
    end else begin
      pbits  <= pbits_next;
      pcount <= pcount_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (fire && (item.op == OP_FLUSH)) |=> (pcount == '0))
    else $error("pending bits survived a flush");

  assert property (@(posedge clk) disable iff (rst)
    (pcount == '0) |-> (pbits == '0))
    else $error("pending bits set with an empty count");

  assert property (@(posedge clk) disable iff (rst)
    (fire && !item.has_code && (item.op != OP_FLUSH)) |=> $stable(pcount) && $stable(pbits))
    else $error("pending state changed by an item without code");

endmodule

### hw/rtl/hcbp_out_fifo.sv
// Small output queue of packed words; takes up to two words per cycle and
// gives one. Depends on hcbp_pkg.
module hcbp_out_fifo (
  input  logic            clk,
  input  logic            rst,
  input  hcbp_pkg::push_t push,
  output logic            has_room,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_byte,
  output logic            last
);
  import hcbp_pkg::*;

  logic [7:0]           data_q [OQ_DEPTH];
  logic [OQ_DEPTH-1:0]  last_q;
  logic [OQ_PTR_W-1:0]  head;
  logic [OQ_PTR_W-1:0]  tail;
  logic [OQ_FILL_W-1:0] fill;
  logic [OQ_PTR_W-1:0]  tail_plus1;
  logic                 pop;

  assign tail_plus1 = tail + OQ_PTR_W'(1);
  assign pop        = out_valid && out_ready;
  assign out_valid  = (fill != '0);
  assign out_byte   = data_q[head];
  assign last       = last_q[head];
  // Room for the largest burst, judged without counting this cycle's read.
  assign has_room   = (fill <= OQ_FILL_W'(OQ_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      data_q[tail] <= push.data0;
      last_q[tail] <= push.last0;
    end
    if (push.count == 2'd2) begin
      data_q[tail_plus1] <= push.data1;
      last_q[tail_plus1] <= push.last1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      fill <= '0;
    end else begin
      tail <= tail + OQ_PTR_W'(push.count);
      if (pop) begin
        head <= head + OQ_PTR_W'(1);
      end
      fill <= fill + OQ_FILL_W'(push.count) - OQ_FILL_W'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> has_room)
    else $error("output queue written without room");

  assert property (@(posedge clk) disable iff (rst)
    fill <= OQ_FILL_W'(OQ_DEPTH))
    else $error("output queue fill out of range");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && (push.count == 2'd0)) |=> $stable(fill) && $stable(head))
    else $error("output queue moved while stalled and idle");

endmodule
